[rtl/aibp_pkg.sv]
// ----------------------------------------------------------------------------
// aibp_pkg: shared types and constants
// Blink and buzzer timing constants, register indexes, indicator bit
// positions and the structs passed between the blocks.
// ----------------------------------------------------------------------------
package aibp_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZER_MUTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USB_WINDOW  = 2'd1;
	localparam logic [15:0] USB_WINDOW_RST = 16'd5000;

	// millisecond timebase
	localparam int unsigned TICK_W = 32;

	// blink half-periods per level; level 2/3 buzzer cadence matches
	// the level 2/3 blink phase (500 ms period, 200 ms period)
	localparam int unsigned HALF_L1 = 500;
	localparam int unsigned HALF_L2 = 250;
	localparam int unsigned HALF_L3 = 100;

	localparam int unsigned PH1_W = $clog2(2 * HALF_L1);
	localparam int unsigned PH2_W = $clog2(2 * HALF_L2);
	localparam int unsigned PH3_W = $clog2(2 * HALF_L3);

	// indicator map bit positions
	localparam int unsigned IND_W         = 5;
	localparam int unsigned IND_CUR_BLINK = 0;
	localparam int unsigned IND_CUR_OK    = 1;
	localparam int unsigned IND_TEMP_OK   = 2;
	localparam int unsigned IND_TEMP_BLNK = 3;
	localparam int unsigned IND_USB       = 4;

	// alarm levels
	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_LOW  = 2'd1;
	localparam logic [1:0] LVL_MID  = 2'd2;
	localparam logic [1:0] LVL_HIGH = 2'd3;

	// timing phase of the tick, sampled when the beat is taken
	typedef struct packed {
		logic lit1;    // level 1 blink phase lit
		logic lit2;    // level 2 blink / buzzer phase on
		logic lit3;    // level 3 blink / buzzer phase on
		logic usb_act; // within the USB window
	} phase_t;

	// stage 1 contents
	typedef struct packed {
		logic       snapshot_ok;
		logic       cur_a_valid;
		logic [1:0] cur_a_level;
		logic       cur_b_valid;
		logic [1:0] cur_b_level;
		logic       temp_valid;
		logic [1:0] temp_level;
		phase_t     phase;
	} s1_t;

	// result beat
	typedef struct packed {
		logic             evaluated;
		logic [IND_W-1:0] indicator_bits;
		logic             buzz_drive;
		logic [1:0]       alarm_sev;
		logic             indicator_changed;
		logic             buzzer_changed;
	} result_t;

endpackage

[rtl/alarm_indicator_buzzer_pattern_top.sv]
// ----------------------------------------------------------------------------
// alarm_indicator_buzzer_pattern_top: alarm indicator and buzzer pattern
// One beat per millisecond tick in, one result beat per tick out.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | beat taken when
//  --------+---------------------------------+-------------------------------
//  in      | in_valid / in_stall + 8 fields  | in_valid  && !in_stall
//  out     | out_valid / out_stall + 6 fields| out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data     | cfg_we (write only)
//
//  A beat passes the input register (stage 1), then the result register.
//  Unless out_stall backs up, throughput is one tick beat per cycle.
//  The timebase advances at the input handshake, so phase and USB window
//  are sampled there; the change flags update as a beat enters the
//  result register. Reset is asynchronous, active low; after reset the
//  first evaluated tick always flags both writes. out_stall backs up
//  through stage 1 into in_stall in the same cycle.
//
module alarm_indicator_buzzer_pattern_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [aibp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aibp_pkg::CFG_DATA_W-1:0] cfg_data,
	// tick input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           snapshot_ok,
	input  logic                           cur_a_valid,
	input  logic [1:0]                     cur_a_level,
	input  logic                           cur_b_valid,
	input  logic [1:0]                     cur_b_level,
	input  logic                           temp_valid,
	input  logic [1:0]                     temp_level,
	input  logic                           usb_pulse,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           evaluated,
	output logic [aibp_pkg::IND_W-1:0]     indicator_bits,
	output logic                           buzz_drive,
	output logic [1:0]                     alarm_sev,
	output logic                           indicator_changed,
	output logic                           buzzer_changed
);
	import aibp_pkg::*;

	// config registers
	logic        mute_q;
	logic [15:0] window_q;

	// pipeline
	logic    vld_s1;
	s1_t     pay_s1;
	logic    out_vld_q;
	result_t res_q;
	result_t res_nxt;
	phase_t  phase;

	logic in_acc;
	logic out_adv;  // result register can load
	logic fire;     // stage 1 beat moves into the result register

	assign out_adv  = !out_vld_q || !out_stall;
	assign fire     = vld_s1 && out_adv;
	assign in_stall = vld_s1 && !out_adv;
	assign in_acc   = in_valid && !in_stall;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q   <= 1'b0;
			window_q <= USB_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUZZER_MUTE: mute_q   <= cfg_data[0];
				REG_USB_WINDOW:  window_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	aibp_timebase u_tb (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (in_acc),
		.usb_pulse  (usb_pulse),
		.usb_window (window_q),
		.phase      (phase)
	);

	// stage 1: input beat plus the phase of its tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_acc)
			vld_s1 <= 1'b1;
		else if (fire)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pay_s1.snapshot_ok <= snapshot_ok;
			pay_s1.cur_a_valid <= cur_a_valid;
			pay_s1.cur_a_level <= cur_a_level;
			pay_s1.cur_b_valid <= cur_b_valid;
			pay_s1.cur_b_level <= cur_b_level;
			pay_s1.temp_valid  <= temp_valid;
			pay_s1.temp_level  <= temp_level;
			pay_s1.phase       <= phase;
		end
	end

	aibp_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.mute   (mute_q),
		.s1     (pay_s1),
		.res    (res_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_adv)
			out_vld_q <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_nxt;
	end

	assign out_valid         = out_vld_q;
	assign evaluated         = res_q.evaluated;
	assign indicator_bits    = res_q.indicator_bits;
	assign buzz_drive        = res_q.buzz_drive;
	assign alarm_sev         = res_q.alarm_sev;
	assign indicator_changed = res_q.indicator_changed;
	assign buzzer_changed    = res_q.buzzer_changed;

endmodule

[rtl/aibp_timebase.sv]
// ----------------------------------------------------------------------------
// aibp_timebase: millisecond counter, blink phases and USB window
// Advances once per accepted tick and gives the phase bits for that tick.
// ----------------------------------------------------------------------------
module aibp_timebase (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            usb_pulse,
	input  logic [15:0]     usb_window,
	output aibp_pkg::phase_t phase
);
	import aibp_pkg::*;

	logic [TICK_W-1:0] tick_q;
	logic [TICK_W-1:0] stamp_q;
	logic              seen_q;
	logic [PH1_W-1:0]  ph1_q;
	logic [PH2_W-1:0]  ph2_q;
	logic [PH3_W-1:0]  ph3_q;
	logic [TICK_W-1:0] age;
	logic              tick_wrap;

	// phase counters restart with the tick counter when it wraps
	assign tick_wrap = (tick_q == {TICK_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			stamp_q <= '0;
			seen_q  <= 1'b0;
			ph1_q   <= '0;
			ph2_q   <= '0;
			ph3_q   <= '0;
		end else if (adv) begin
			tick_q <= tick_q + 1'b1;
			if (usb_pulse) begin
				stamp_q <= tick_q;
				seen_q  <= 1'b1;
			end
			if (tick_wrap) begin
				ph1_q <= '0;
				ph2_q <= '0;
				ph3_q <= '0;
			end else begin
				ph1_q <= (ph1_q == PH1_W'(2 * HALF_L1 - 1)) ? '0 : ph1_q + 1'b1;
				ph2_q <= (ph2_q == PH2_W'(2 * HALF_L2 - 1)) ? '0 : ph2_q + 1'b1;
				ph3_q <= (ph3_q == PH3_W'(2 * HALF_L3 - 1)) ? '0 : ph3_q + 1'b1;
			end
		end
	end

	// a pulse on this tick stamps "now", so its age is zero
	assign age = usb_pulse ? '0 : (tick_q - stamp_q);

	always_comb begin
		phase.lit1    = (ph1_q < PH1_W'(HALF_L1));
		phase.lit2    = (ph2_q < PH2_W'(HALF_L2));
		phase.lit3    = (ph3_q < PH3_W'(HALF_L3));
		phase.usb_act = (seen_q | usb_pulse) && (age < {{(TICK_W-16){1'b0}}, usb_window});
	end

endmodule

[rtl/aibp_eval.sv]
// ----------------------------------------------------------------------------
// aibp_eval: alarm level, indicator map and buzzer decision
// Holds the last written indicator map and buzzer level for change flags.
// ----------------------------------------------------------------------------
module aibp_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              mute,
	input  aibp_pkg::s1_t     s1,
	output aibp_pkg::result_t res
);
	import aibp_pkg::*;

	logic             ind_wr_q;  // a map has been written since reset
	logic [IND_W-1:0] last_ind_q;
	logic             buz_wr_q;
	logic             last_buz_q;

	logic [1:0]       cur;
	logic [1:0]       tmp;
	logic [1:0]       alarm;
	logic [IND_W-1:0] map;
	logic             buzz;
	logic             ind_ch;
	logic             buz_ch;

	function automatic logic blink(input logic [1:0] lvl, input phase_t ph);
		logic r;
		unique case (lvl)
			LVL_LOW:  r = ph.lit1;
			LVL_MID:  r = ph.lit2;
			LVL_HIGH: r = ph.lit3;
			default:  r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		cur = s1.cur_a_valid ? s1.cur_a_level : LVL_NONE;
		if (s1.cur_b_valid && (s1.cur_b_level > cur))
			cur = s1.cur_b_level;
		tmp   = s1.temp_valid ? s1.temp_level : LVL_NONE;
		alarm = (tmp > cur) ? tmp : cur;

		map                = '0;
		map[IND_CUR_BLINK] = blink(cur, s1.phase);
		map[IND_CUR_OK]    = s1.cur_a_valid && s1.cur_b_valid && (cur == LVL_NONE);
		map[IND_TEMP_OK]   = s1.temp_valid && (tmp == LVL_NONE);
		map[IND_TEMP_BLNK] = blink(tmp, s1.phase);
		map[IND_USB]       = s1.phase.usb_act;

		if (mute)
			buzz = 1'b0;
		else if (alarm == LVL_HIGH)
			buzz = s1.phase.lit3;
		else if (alarm == LVL_MID)
			buzz = s1.phase.lit2;
		else
			buzz = 1'b0;

		ind_ch = !ind_wr_q || (map != last_ind_q);
		buz_ch = !buz_wr_q || (buzz != last_buz_q);

		// skipped tick: everything reads zero
		if (s1.snapshot_ok) begin
			res.evaluated         = 1'b1;
			res.indicator_bits    = map;
			res.buzz_drive        = buzz;
			res.alarm_sev         = alarm;
			res.indicator_changed = ind_ch;
			res.buzzer_changed    = buz_ch;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ind_wr_q <= 1'b0;
			buz_wr_q <= 1'b0;
		end else if (fire && s1.snapshot_ok) begin
			ind_wr_q <= 1'b1;
			buz_wr_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && s1.snapshot_ok) begin
			if (ind_ch)
				last_ind_q <= map;
			if (buz_ch)
				last_buz_q <= buzz;
		end
	end

endmodule

[rtl/aibp_checker.sv]
// ----------------------------------------------------------------------------
// aibp_checker: port-level checks for the alarm indicator block
// Output handshake rules and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module aibp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       evaluated,
	input logic [aibp_pkg::IND_W-1:0] indicator_bits,
	input logic                       buzz_drive,
	input logic [1:0]                 alarm_sev,
	input logic                       indicator_changed,
	input logic                       buzzer_changed
);
	import aibp_pkg::*;

	// stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(indicator_bits) && $stable(buzz_drive)
			&& $stable(alarm_sev) && $stable(evaluated))
		else $error("stalled result beat changed");

	// skipped tick reads all zero
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evaluated |-> indicator_bits == '0 && !buzz_drive
			&& alarm_sev == LVL_NONE && !indicator_changed && !buzzer_changed)
		else $error("skipped tick with nonzero result");

	// buzzer only sounds at levels 2 and 3
	a_buzz_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && buzz_drive |-> alarm_sev == LVL_MID || alarm_sev == LVL_HIGH)
		else $error("buzzer on below level 2");

	// currents normal excludes current blink
	a_cur_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && indicator_bits[IND_CUR_OK] |-> !indicator_bits[IND_CUR_BLINK])
		else $error("current ok and current blink both lit");

endmodule

bind alarm_indicator_buzzer_pattern_top aibp_checker u_aibp_checker (.*);
